// ----- hdl/hfr_pkg.sv -----
// shared types and codes for the hamming 8/4 frame receiver
`default_nettype none

package hfr_pkg;

  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_e;

  // register byte addresses on the configuration port
  localparam logic [2:0] ADDR_BEGIN_MARKER = 3'd0;
  localparam logic [2:0] ADDR_END_MARKER   = 3'd4;

  localparam logic [7:0] BEGIN_MARKER_RST = 8'h02;
  localparam logic [7:0] END_MARKER_RST   = 8'h03;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] code_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       message_ready;
    logic [5:0] message_length;
    logic       receiving;
    logic       pair_error;
  } out_item_t;

  // decoded nibble with its uncorrectable flag
  typedef struct packed {
    logic       err;
    logic [3:0] nib;
  } nibble_t;

endpackage

`default_nettype wire

// ----- hdl/hfr_decode.sv -----
// secded decoder for one extended hamming 8/4 code byte
`default_nettype none

module hfr_decode (
  input  wire logic [7:0]      code_i,
  output hfr_pkg::nibble_t     dec_o
);
  import hfr_pkg::*;

  logic [3:0] data;
  logic [3:0] par;
  logic [3:0] syn;
  logic [2:0] cnt;

  assign data = code_i[7:4];

  // parity bit i covers the three data bits other than i
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      par[i] = ^(data & ~(4'b0001 << i));
    end
  end

  assign syn = code_i[3:0] ^ par;
  assign cnt = 3'(syn[0]) + 3'(syn[1]) + 3'(syn[2]) + 3'(syn[3]);

  always_comb begin
    dec_o = '0;
    case (cnt)
      3'd0, 3'd1: begin
        // clean, or a single parity bit hit
        dec_o.nib = data;
      end
      3'd3: begin
        // one data bit flipped: its position is the syndrome's zero
        dec_o.nib = data ^ ~syn;
      end
      default: begin
        dec_o.err = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/hamming_8_4_frame_receiver.sv -----
// top level: hamming 8/4 frame receiver with message store
//
//  channel   dir  payload                     handshake
//  in        in   hfr_pkg::in_item_t          in_valid_i / in_stall_o
//  out       out  hfr_pkg::out_item_t         out_valid_o / out_stall_i
//  cfg       in   begin/end marker registers  apb read/write, pready tied high
//
//  one request is taken per cycle while the input is not stalled; its result passes
//  through the store read stage, loaded at acceptance, and then the output register
//  throughput is one request per clock while the input is not stalled, bounded by the
//  single store port that serves either one write or one read per request
//  reset clears all control state and sets the markers to their defaults; store contents stay undefined
//  a stalled output holds the pipeline; the input stalls only when both stages are
//  full and the output is stalled
`default_nettype none

module hamming_8_4_frame_receiver #(
  parameter int unsigned MESSAGE_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  hfr_pkg::in_item_t       in_data_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hfr_pkg::out_item_t      out_data_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import hfr_pkg::*;

  localparam int unsigned AW   = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
  localparam int unsigned LAST = MESSAGE_DEPTH - 1;

  // configuration registers
  logic [7:0] begin_marker_q, end_marker_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_marker_q <= BEGIN_MARKER_RST;
      end_marker_q   <= END_MARKER_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ADDR_END_MARKER[2]) begin
        end_marker_q <= pwdata[7:0];
      end else begin
        begin_marker_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == ADDR_END_MARKER[2]) ? {24'd0, end_marker_q}
                                                   : {24'd0, begin_marker_q};

  // receiver control state
  logic          phase_q, phase_d;
  nibble_t       high_q, high_d;
  logic          in_frame_q, in_frame_d;
  logic          ready_q, ready_d;
  logic [AW-1:0] widx_q, widx_d;
  logic          wrapped_q, wrapped_d;   // store filled all the way round since clear

  // pipeline
  logic       s1_valid_q, s1_valid_d;
  out_item_t  s1_stat_q;
  logic       s1_hit_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       s1_adv;
  logic       accept;

  // store port
  logic [7:0]    mem_q [MESSAGE_DEPTH];
  logic [7:0]    rd_data_q;
  logic          mem_we, rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  nibble_t    dec;
  logic [7:0] pair_byte;
  logic       perr;
  logic       hit;

  hfr_decode u_decode (
    .code_i (in_data_i.code_byte),
    .dec_o  (dec)
  );

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign pair_byte = {high_q.nib, dec.nib};
  assign waddr     = widx_q;
  assign wdata     = pair_byte;
  assign raddr     = AW'(in_data_i.read_index);

  // a read hits only inside the depth and on an entry written since the last clear
  assign hit = (32'(in_data_i.read_index) < MESSAGE_DEPTH) &&
               (wrapped_q || (32'(in_data_i.read_index) < 32'(widx_q)));

  always_comb begin
    phase_d    = phase_q;
    high_d     = high_q;
    in_frame_d = in_frame_q;
    ready_d    = ready_q;
    widx_d     = widx_q;
    wrapped_d  = wrapped_q;
    perr       = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    if (accept) begin
      case (in_data_i.mode)
        MODE_CODE: begin
          if (!phase_q) begin
            high_d  = dec;
            phase_d = 1'b1;
          end else begin
            phase_d = 1'b0;
            if (high_q.err || dec.err) begin
              perr = 1'b1;
            end else if (in_frame_q) begin
              if (pair_byte != end_marker_q) begin
                mem_we = 1'b1;
                if (widx_q == AW'(LAST)) begin
                  widx_d    = '0;
                  wrapped_d = 1'b1;
                end else begin
                  widx_d = widx_q + 1'b1;
                end
              end else begin
                in_frame_d = 1'b0;
                ready_d    = 1'b1;
              end
            end else if (pair_byte == begin_marker_q) begin
              in_frame_d = 1'b1;
            end
          end
        end
        MODE_READ: begin
          rd_en = 1'b1;
        end
        MODE_CLEAR: begin
          // emptying the store is done by forgetting its fill level
          widx_d    = '0;
          wrapped_d = 1'b0;
          ready_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      high_q     <= '0;
      in_frame_q <= 1'b0;
      ready_q    <= 1'b0;
      widx_q     <= '0;
      wrapped_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      high_q     <= high_d;
      in_frame_q <= in_frame_d;
      ready_q    <= ready_d;
      widx_q     <= widx_d;
      wrapped_q  <= wrapped_d;
    end
  end

  // message store, one access per request, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  // stage 1: status after the step, waiting for the store read
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_stat_q.read_data      <= '0;
      s1_stat_q.message_ready  <= ready_d;
      s1_stat_q.message_length <= 6'(widx_d);
      s1_stat_q.receiving      <= in_frame_d;
      s1_stat_q.pair_error     <= perr;
      s1_hit_q                 <= rd_en && hit;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= '{read_data:      s1_hit_q ? rd_data_q : 8'd0,
                 message_ready:  s1_stat_q.message_ready,
                 message_length: s1_stat_q.message_length,
                 receiving:      s1_stat_q.receiving,
                 pair_error:     s1_stat_q.pair_error};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/hfr_checker.sv -----
// port-level checks for the hamming 8/4 frame receiver, bound to the top level
`default_nettype none

module hfr_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input hfr_pkg::out_item_t       out_data_o
);
  import hfr_pkg::*;

  logic out_acc;
  logic last_ready_q;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ready_q <= 1'b0;
    end else if (out_acc) begin
      last_ready_q <= out_data_o.message_ready;
    end
  end

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // read data and a dropped pair come from different modes
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.pair_error |-> out_data_o.read_data == 8'd0)
    else $error("pair error with read data");

  // ready only comes up when an end marker closes the frame
  a_ready_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.message_ready && !last_ready_q |-> !out_data_o.receiving)
    else $error("ready raised inside a frame");

endmodule

bind hamming_8_4_frame_receiver hfr_checker u_hfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
